@@ hw/rtl/signed_integer_to_radix_text_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the signed integer to radix text block
// Clocked on i_clk and disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SIGNED_INTEGER_TO_RADIX_TEXT_ASSERT_SVH
`define SIGNED_INTEGER_TO_RADIX_TEXT_ASSERT_SVH

// Condition in the same cycle implies the property.
`define SIT_ASSERT_IMP(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Condition implies the property in the next cycle.
`define SIT_ASSERT_NXT(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

@@ hw/rtl/sit_pkg.sv @@
// ----------------------------------------------------------------------------
// sit_pkg
// Types and constants shared by the signed integer to radix text block.
// ----------------------------------------------------------------------------
package sit_pkg;

    localparam int NUM_W      = 32;  // width of the input number
    localparam int DIGIT_W    = 4;   // one digit value, radix up to 16
    localparam int RADIX_W    = 5;   // width of the base_size register
    localparam int CHAR_W     = 8;   // width of one symbol byte
    localparam int SYM_COUNT  = 16;  // symbol slots in the two symbol registers
    localparam int SYM_W      = SYM_COUNT * CHAR_W;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 2;
    localparam int DIV_BITS   = 8;   // quotient bits resolved per divider cycle
    localparam int DIV_STEPS  = NUM_W / DIV_BITS;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
    localparam int STACK_DEPTH = NUM_W;  // radix 2 gives at most 32 digits
    localparam int COUNT_W    = $clog2(STACK_DEPTH + 1);

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE_SIZE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYMBOLS_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SYMBOLS_HIGH = 2'd2;

    // Status of the shared divider as seen by the sequencer.
    typedef struct packed {
        logic                 done;
        logic [NUM_W-1:0]     quotient;
        logic [DIGIT_W-1:0]   remainder;
    } t_div_result;

endpackage

@@ hw/rtl/sit_base_check.sv @@
// ----------------------------------------------------------------------------
// sit_base_check
// Decides whether the configured radix and symbol table form a usable base.
// ----------------------------------------------------------------------------
module sit_base_check #(
    parameter int MAX_SYMBOLS = 16
) (
    input  logic [sit_pkg::RADIX_W-1:0] i_base_size,
    input  logic [sit_pkg::SYM_W-1:0]   i_symbols,
    output logic                        o_ok
);

    logic [sit_pkg::CHAR_W-1:0] c_sym;

    // Every symbol in use is tested against the forbidden bytes and against
    // every later symbol in use; all compares are independent.
    always_comb begin
        o_ok  = 1'b1;
        c_sym = '0;
        if (i_base_size < sit_pkg::RADIX_W'(2) ||
            i_base_size > sit_pkg::RADIX_W'(MAX_SYMBOLS)) begin
            o_ok = 1'b0;
        end
        for (int i = 0; i < MAX_SYMBOLS; i++) begin
            if (sit_pkg::RADIX_W'(i) < i_base_size) begin
                c_sym = i_symbols[i*sit_pkg::CHAR_W +: sit_pkg::CHAR_W];
                if (c_sym == sit_pkg::CHAR_NUL || c_sym == sit_pkg::CHAR_PLUS ||
                    c_sym == sit_pkg::CHAR_MINUS || c_sym == sit_pkg::CHAR_SPACE) begin
                    o_ok = 1'b0;
                end
                for (int j = i + 1; j < MAX_SYMBOLS; j++) begin
                    if (sit_pkg::RADIX_W'(j) < i_base_size &&
                        i_symbols[j*sit_pkg::CHAR_W +: sit_pkg::CHAR_W] == c_sym) begin
                        o_ok = 1'b0;
                    end
                end
            end
        end
    end

endmodule

@@ hw/rtl/sit_divider.sv @@
// ----------------------------------------------------------------------------
// sit_divider
// Restoring divider of a 32-bit value by a small radix, eight quotient bits
// per cycle, giving quotient and remainder after four steps.
// ----------------------------------------------------------------------------
module sit_divider (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [sit_pkg::NUM_W-1:0]     i_dividend,
    input  logic [sit_pkg::RADIX_W-1:0]   i_divisor,
    output sit_pkg::t_div_result          o_result
);

    logic [sit_pkg::NUM_W-1:0]     r_work;
    logic [sit_pkg::NUM_W-1:0]     n_work;
    logic [sit_pkg::DIGIT_W-1:0]   r_rem;
    logic [sit_pkg::DIGIT_W-1:0]   n_rem;
    logic [sit_pkg::DIV_CNT_W-1:0] r_cnt;
    logic                          r_busy;
    logic                          r_done;
    logic [sit_pkg::RADIX_W-1:0]   c_trial;

    // The dividend shifts out at the top while quotient bits shift in at the
    // bottom, so r_work ends up holding the quotient. The partial remainder
    // always stays below the divisor, hence four bits suffice.
    always_comb begin
        n_work  = r_work;
        n_rem   = r_rem;
        c_trial = '0;
        for (int k = 0; k < sit_pkg::DIV_BITS; k++) begin
            c_trial = {n_rem, n_work[sit_pkg::NUM_W-1]};
            n_work  = {n_work[sit_pkg::NUM_W-2:0], 1'b0};
            if (c_trial >= i_divisor) begin
                c_trial   = c_trial - i_divisor;
                n_work[0] = 1'b1;
            end
            n_rem = c_trial[sit_pkg::DIGIT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == sit_pkg::DIV_CNT_W'(sit_pkg::DIV_STEPS - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_work <= i_dividend;
            r_rem  <= '0;
        end else if (r_busy) begin
            r_work <= n_work;
            r_rem  <= n_rem;
        end
    end

    assign o_result.done      = r_done;
    assign o_result.quotient  = r_work;
    assign o_result.remainder = r_rem;

endmodule

@@ hw/rtl/signed_integer_to_radix_text.sv @@
// ----------------------------------------------------------------------------
// signed_integer_to_radix_text
// Formats a signed 32-bit number as character codes in a configured radix.
// ----------------------------------------------------------------------------
// A number is taken when start is high and busy is low. Its characters come
// out one per cycle on o_character, each marked by o_strobe for one cycle and
// the final one by o_last; the receiver cannot stall, so it must take every
// strobed character. A negative number begins with '-' (0x2D), digits follow
// most significant first. If the base is invalid (size below 2 or above
// MAX_SYMBOLS, a symbol of 0x00, '+', '-' or space, or a repeated symbol)
// the number is dropped with no output. Each digit is computed in the
// shared divider, which resolves eight quotient bits per cycle. The last
// character is on the outputs in the same cycle that busy falls.
// ----------------------------------------------------------------------------
module signed_integer_to_radix_text #(
    parameter int MAX_SYMBOLS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [sit_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [sit_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                             start,
    input  logic signed [sit_pkg::NUM_W-1:0] i_number,
    output logic                             busy,
    output logic                             o_strobe,
    output logic [sit_pkg::CHAR_W-1:0]       o_character,
    output logic                             o_last
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_SIGN = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    logic [sit_pkg::RADIX_W-1:0]    r_base_size;
    logic [sit_pkg::SYM_W-1:0]      r_symbols;

    logic [1:0]                     r_state;
    logic [1:0]                     n_state;
    logic                           r_neg;
    logic                           n_neg;
    logic [sit_pkg::COUNT_W-1:0]    r_nd;
    logic [sit_pkg::COUNT_W-1:0]    n_nd;
    logic [sit_pkg::STACK_DEPTH-1:0][sit_pkg::DIGIT_W-1:0] r_stack;
    logic [sit_pkg::STACK_DEPTH-1:0][sit_pkg::DIGIT_W-1:0] n_stack;
    logic                           r_strobe;
    logic                           n_strobe;
    logic [sit_pkg::CHAR_W-1:0]     r_char;
    logic [sit_pkg::CHAR_W-1:0]     n_char;
    logic                           r_last;
    logic                           n_last;

    logic                           c_accept;
    logic                           c_base_ok;
    logic [sit_pkg::NUM_W-1:0]      c_mag;
    logic                           c_div_start;
    logic [sit_pkg::NUM_W-1:0]      c_dividend;
    sit_pkg::t_div_result           w_div;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_size <= '0;
            r_symbols   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                sit_pkg::CFG_BASE_SIZE:
                    r_base_size <= i_cfg_data[sit_pkg::RADIX_W-1:0];
                sit_pkg::CFG_SYMBOLS_LOW:
                    r_symbols[sit_pkg::CFG_DATA_W-1:0] <= i_cfg_data;
                sit_pkg::CFG_SYMBOLS_HIGH:
                    r_symbols[sit_pkg::SYM_W-1:sit_pkg::CFG_DATA_W] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    sit_base_check #(
        .MAX_SYMBOLS (MAX_SYMBOLS)
    ) u_base_check (
        .i_base_size (r_base_size),
        .i_symbols   (r_symbols),
        .o_ok        (c_base_ok)
    );

    assign c_accept = start && (r_state == S_IDLE);
    assign c_mag    = i_number[sit_pkg::NUM_W-1] ? (~i_number + 1'b1) : i_number;

    // The divider restarts on its own quotient in the cycle it finishes, so
    // consecutive digits follow without a gap.
    always_comb begin
        c_div_start = 1'b0;
        c_dividend  = c_mag;
        if (c_accept && c_base_ok) begin
            c_div_start = 1'b1;
        end else if (r_state == S_DIV && w_div.done && w_div.quotient != '0) begin
            c_div_start = 1'b1;
            c_dividend  = w_div.quotient;
        end
    end

    sit_divider u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (c_div_start),
        .i_dividend (c_dividend),
        .i_divisor  (r_base_size),
        .o_result   (w_div)
    );

    // Sequencer: digits are pushed least significant first onto a stack and
    // popped most significant first.
    always_comb begin
        n_state  = r_state;
        n_neg    = r_neg;
        n_nd     = r_nd;
        n_stack  = r_stack;
        n_strobe = 1'b0;
        n_char   = r_char;
        n_last   = r_last;
        case (r_state)
            S_IDLE: begin
                if (c_accept && c_base_ok) begin
                    n_state = S_DIV;
                    n_neg   = i_number[sit_pkg::NUM_W-1];
                    n_nd    = '0;
                end
            end
            S_DIV: begin
                if (w_div.done) begin
                    n_stack = {r_stack[sit_pkg::STACK_DEPTH-2:0], w_div.remainder};
                    n_nd    = r_nd + 1'b1;
                    if (w_div.quotient == '0) begin
                        n_state = r_neg ? S_SIGN : S_EMIT;
                    end
                end
            end
            S_SIGN: begin
                n_strobe = 1'b1;
                n_char   = sit_pkg::CHAR_MINUS;
                n_last   = 1'b0;
                n_state  = S_EMIT;
            end
            S_EMIT: begin
                n_strobe = 1'b1;
                n_char   = r_symbols[{r_stack[0], 3'b000} +: sit_pkg::CHAR_W];
                n_last   = (r_nd == sit_pkg::COUNT_W'(1));
                n_stack  = {{sit_pkg::DIGIT_W{1'b0}},
                            r_stack[sit_pkg::STACK_DEPTH-1:1]};
                n_nd     = r_nd - 1'b1;
                if (r_nd == sit_pkg::COUNT_W'(1)) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_nd     <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_nd     <= n_nd;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_neg   <= n_neg;
        r_stack <= n_stack;
        r_char  <= n_char;
        r_last  <= n_last;
    end

    assign busy        = (r_state != S_IDLE);
    assign o_strobe    = r_strobe;
    assign o_character = r_char;
    assign o_last      = r_last;

`include "signed_integer_to_radix_text_assert.svh"

    `SIT_ASSERT_NXT(a_gap_after_last, r_strobe && r_last, !r_strobe, "character right after last")
    `SIT_ASSERT_NXT(a_quiet_after_accept, c_accept, !r_strobe, "character right after a transfer")
    `SIT_ASSERT_IMP(a_emit_has_digits, r_state == S_EMIT, r_nd != '0, "emitting with no digits")
    `SIT_ASSERT_IMP(a_div_done_in_div, w_div.done, r_state == S_DIV, "divider done outside division")

endmodule
